// File: design/vml_pkg.sv
// Package for the vector magnitude limiter: widths and payload types.
// No dependencies.
package vml_pkg;
    localparam int unsigned CompW = 32;
    localparam int unsigned LimW = 31;
    localparam int unsigned SqW = 64;
    localparam int unsigned RootW = 32;
    localparam int unsigned ProdW = 63;
    localparam int unsigned QuoW = 32;

    typedef struct packed {
        logic signed [CompW-1:0] x_in;
        logic signed [CompW-1:0] y_in;
        logic [LimW-1:0] limit_mag;
    } t_vml_in;

    typedef struct packed {
        logic signed [CompW-1:0] x_out;
        logic signed [CompW-1:0] y_out;
        logic was_limited;
    } t_vml_out;
endpackage

// File: design/vml_if.sv
// Valid/ready channel interfaces for the limiter input and output.
// Depends on vml_pkg.
interface vml_in_if import vml_pkg::*; ();
    logic valid;
    logic ready;
    t_vml_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vml_out_if import vml_pkg::*; ();
    logic valid;
    logic ready;
    t_vml_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/vml_sqrt_cell.sv
// One cell of the square-root chain: retires one root bit per cycle while enabled.
// Depends on vml_pkg.
module vml_sqrt_cell import vml_pkg::*; #(
    parameter int unsigned BitIdx = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SqW-1:0]   i_rem,
    input  logic [RootW-1:0] i_root,
    output logic [SqW-1:0]   o_rem,
    output logic [RootW-1:0] o_root
);
    logic [SqW-1:0] trial;
    logic [SqW-1:0] n_rem;
    logic [RootW-1:0] n_root;
    logic [SqW-1:0] r_rem;
    logic [RootW-1:0] r_root;

    always_comb begin
        trial = ({{(SqW-RootW){1'b0}}, i_root} << (BitIdx + 1))
              | (SqW'(1) << (2 * BitIdx));
        n_rem = i_rem;
        n_root = i_root;
        if (i_rem >= trial) begin
            n_rem = i_rem - trial;
            n_root = i_root | (RootW'(1) << BitIdx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem = r_rem;
    assign o_root = r_root;
endmodule

// File: design/vml_div_cell.sv
// One cell of the restoring divider chain: retires one quotient bit per cycle while enabled.
// Depends on vml_pkg.
module vml_div_cell import vml_pkg::*; #(
    parameter int unsigned BitIdx = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [ProdW-1:0] i_rem,
    input  logic [QuoW-1:0]  i_quo,
    input  logic [RootW-1:0] i_den,
    output logic [ProdW-1:0] o_rem,
    output logic [QuoW-1:0]  o_quo
);
    logic [ProdW-1:0] hi;
    logic [ProdW-1:0] n_rem;
    logic [QuoW-1:0] n_quo;
    logic [ProdW-1:0] r_rem;
    logic [QuoW-1:0] r_quo;

    always_comb begin
        hi = i_rem >> BitIdx;
        n_rem = i_rem;
        n_quo = i_quo;
        if (hi >= {{(ProdW-RootW){1'b0}}, i_den}) begin
            n_rem = i_rem - ({{(ProdW-RootW){1'b0}}, i_den} << BitIdx);
            n_quo = i_quo | (QuoW'(1) << BitIdx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule

// File: design/vector_magnitude_limit_core.sv
// Vector magnitude limiter top level: squares, a 32-cell root chain, then
// two 32-cell divider chains. The result passes through 68 register stages
// after the input transfer. Throughput is one transfer per cycle;
// the whole pipeline stalls only when the output register is full and not
// taken. Reset clears the valid bits.
// Depends on vml_pkg, vml_if, vml_sqrt_cell and vml_div_cell.
module vector_magnitude_limit_core import vml_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    vml_in_if.sink    i_in,
    vml_out_if.source o_out
);
    localparam int unsigned Depth = 2 + RootW + 1 + QuoW;

    logic en;
    logic [Depth-1:0] r_vld;

    // Side payload carried beside the chains.
    typedef struct packed {
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic [LimW-1:0] lim;
        logic [CompW:0] xm;
        logic [CompW:0] ym;
        logic xneg;
        logic yneg;
        logic lmt;
    } t_side;

    t_side side [Depth];
    logic [SqW-1:0] r_xsq, r_ysq, r_lsq;
    logic [SqW-1:0] r_sum;
    logic [SqW-1:0] srem [RootW+1];
    logic [RootW-1:0] sroot [RootW+1];
    logic [ProdW-1:0] r_xp, r_yp;
    logic [RootW-1:0] r_den;
    logic [RootW-1:0] den [QuoW+1];
    logic [ProdW-1:0] xrem [QuoW+1], yrem [QuoW+1];
    logic [QuoW-1:0] xquo [QuoW+1], yquo [QuoW+1];
    t_vml_out r_out;
    logic r_ovld;
    t_side s0;
    t_side s1;

    assign en = !r_ovld || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], i_in.valid};
            r_ovld <= r_vld[Depth-1];
        end
    end

    always_comb begin
        s0.x = i_in.data.x_in;
        s0.y = i_in.data.y_in;
        s0.lim = i_in.data.limit_mag;
        s0.xneg = i_in.data.x_in[CompW-1];
        s0.yneg = i_in.data.y_in[CompW-1];
        s0.xm = s0.xneg ? (CompW+1)'(-$signed({1'b1, i_in.data.x_in}))
                        : {1'b0, i_in.data.x_in};
        s0.ym = s0.yneg ? (CompW+1)'(-$signed({1'b1, i_in.data.y_in}))
                        : {1'b0, i_in.data.y_in};
        s0.lmt = 1'b0;
    end

    always_comb begin
        s1 = side[0];
        s1.lmt = (r_xsq + r_ysq) > r_lsq;
    end

    // Stage 0: squares. Stage 1: sum and compare.
    always_ff @(posedge i_clk) begin
        if (en) begin
            side[0] <= s0;
            r_xsq <= SqW'(s0.xm) * SqW'(s0.xm);
            r_ysq <= SqW'(s0.ym) * SqW'(s0.ym);
            r_lsq <= SqW'(s0.lim) * SqW'(s0.lim);
            side[1] <= s1;
            r_sum <= r_xsq + r_ysq;
        end
    end

    assign srem[0] = r_sum;
    assign sroot[0] = '0;

    for (genvar g = 0; g < RootW; g++) begin : g_sqrt
        vml_sqrt_cell #(.BitIdx(RootW-1-g)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_rem(srem[g]), .i_root(sroot[g]),
            .o_rem(srem[g+1]), .o_root(sroot[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) side[2+g] <= side[1+g];
        end
    end

    // Products and divisor register. A zero root only occurs when not limited.
    always_ff @(posedge i_clk) begin
        if (en) begin
            side[2+RootW] <= side[1+RootW];
            r_xp <= ProdW'(side[1+RootW].xm) * ProdW'(side[1+RootW].lim);
            r_yp <= ProdW'(side[1+RootW].ym) * ProdW'(side[1+RootW].lim);
            r_den <= (sroot[RootW] == '0) ? RootW'(1) : sroot[RootW];
        end
    end

    assign xrem[0] = r_xp;
    assign yrem[0] = r_yp;
    assign xquo[0] = '0;
    assign yquo[0] = '0;
    assign den[0] = r_den;

    for (genvar g = 0; g < QuoW; g++) begin : g_div
        vml_div_cell #(.BitIdx(QuoW-1-g)) u_xcell (
            .i_clk(i_clk), .i_en(en), .i_rem(xrem[g]), .i_quo(xquo[g]),
            .i_den(den[g]), .o_rem(xrem[g+1]), .o_quo(xquo[g+1])
        );
        vml_div_cell #(.BitIdx(QuoW-1-g)) u_ycell (
            .i_clk(i_clk), .i_en(en), .i_rem(yrem[g]), .i_quo(yquo[g]),
            .i_den(den[g]), .o_rem(yrem[g+1]), .o_quo(yquo[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                side[3+RootW+g] <= side[2+RootW+g];
                den[g+1] <= den[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (side[Depth-1].lmt) begin
                r_out.x_out <= side[Depth-1].xneg ? -$signed(xquo[QuoW])
                                                  : $signed(xquo[QuoW]);
                r_out.y_out <= side[Depth-1].yneg ? -$signed(yquo[QuoW])
                                                  : $signed(yquo[QuoW]);
            end else begin
                r_out.x_out <= side[Depth-1].x;
                r_out.y_out <= side[Depth-1].y;
            end
            r_out.was_limited <= side[Depth-1].lmt;
        end
    end

    assign o_out.valid = r_ovld;
    assign o_out.data = r_out;
endmodule

// File: design/vml_checker.sv
// Port-level checker for the vector magnitude limiter, bound to the top.
// Depends on vml_pkg.
module vml_checker import vml_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_vml_out o_out_data
);
    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data);
    endproperty
    a_hold: assert property (p_hold) else $error("output changed while stalled");

    property p_ready;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!o_out_valid || i_out_ready) |-> i_in_ready;
    endproperty
    a_ready: assert property (p_ready) else $error("input stalled without cause");

    property p_block;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_out_valid && !i_out_ready |-> !i_in_ready;
    endproperty
    a_block: assert property (p_block) else $error("input taken while full");

    property p_rst;
        @(posedge i_clk) !i_rst_n |=> !o_out_valid;
    endproperty
    a_rst: assert property (p_rst) else $error("output valid after reset");
endmodule

bind vector_magnitude_limit_core vml_checker u_vml_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .o_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .o_out_data(o_out.data)
);
